>>> rtl/tpp_pkg.sv
// ----------------------------------------------------------------------------
// Tangent plane projector package
// Shared widths, field codes, register indexes and item types.
// ----------------------------------------------------------------------------
package tpp_pkg;

  localparam int COORD_W   = 24;
  localparam int NORM_W    = 16;
  localparam int NORM_FRAC = 14;
  localparam int LEN_SCALE = 10;
  localparam int NZ_THRESH = 1639;

  localparam int DIFF_W  = COORD_W + 1;
  localparam int AXIS_W  = 20;
  localparam int PROD_W  = DIFF_W + AXIS_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int DOT_W   = SUM_W - NORM_FRAC;
  localparam int DOTP_W  = DOT_W + NORM_W;
  localparam int REM_W   = SUM_W + LEN_SCALE + 1;
  localparam int DEN_W   = 32;
  localparam int QUO_W   = COORD_W;
  localparam int RAD_W   = 2 * DEN_W;
  localparam int LEN2_W  = 2 * AXIS_W + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 3'd5;

  localparam logic [1:0] KIND_POINT  = 2'd0;
  localparam logic [1:0] KIND_VECTOR = 2'd1;
  localparam logic [1:0] KIND_PLANE  = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [AXIS_W-1:0]  axis_t;

  typedef struct packed {
    logic [1:0] kind;
    coord_t     in_x;
    coord_t     in_y;
    coord_t     in_z;
  } in_item_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
  } out_item_t;

  typedef struct packed {
    coord_t [2:0]     center;
    norm_t  [2:0]     normal;
    axis_t  [2:0]     xa;
    axis_t  [2:0]     ya;
    logic [DEN_W-1:0] den_x;
    logic [DEN_W-1:0] den_y;
  } cfg_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic ovf;
  } div_flags_t;

  typedef struct packed {
    logic [REM_W-1:0] t;
    div_flags_t       flags;
  } div_req_t;

  typedef struct packed {
    logic [1:0] kind;
    out_item_t  res;
  } side_t;

endpackage

>>> rtl/tpp_cfg.sv
// ----------------------------------------------------------------------------
// Tangent plane projector configuration
// Holds center and normal, derives the local axes and their lengths.
// ----------------------------------------------------------------------------
module tpp_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [tpp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tpp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           busy_o,
  output tpp_pkg::cfg_t                  cfg_o
);
  import tpp_pkg::*;

  localparam int PH_LAST = 2 + RAD_W / 2;
  localparam int PH_W    = $clog2(PH_LAST + 1);
  localparam logic [PH_W-1:0] PH_AXIS      = PH_W'(0);
  localparam logic [PH_W-1:0] PH_CROSS     = PH_W'(1);
  localparam logic [PH_W-1:0] PH_LOAD      = PH_W'(2);
  localparam logic [PH_W-1:0] PH_ROOT_LAST = PH_W'(PH_LAST);
  localparam int CROSS_W = NORM_W + AXIS_W + 1;
  localparam int SREM_W  = DEN_W + 3;

  coord_t center_q [3];
  norm_t  normal_q [3];
  logic            busy_q;
  logic [PH_W-1:0] phase_q;

  axis_t xa_q [3];
  axis_t ya_q [3];
  axis_t xa_d [3];
  axis_t ya_d [3];
  logic [RAD_W-1:0]  rad_q  [2];
  logic [SREM_W-1:0] srem_q [2];
  logic [DEN_W-1:0]  root_q [2];
  logic [RAD_W-1:0]  rad_d  [2];
  logic [SREM_W-1:0] srem_d [2];
  logic [DEN_W-1:0]  root_d [2];

  logic signed [CROSS_W-1:0] cross_c [3];
  logic signed [CROSS_W-1:0] cross_r [3];
  logic signed [LEN2_W-1:0]  len2_x;
  logic signed [LEN2_W-1:0]  len2_y;
  logic [SREM_W-1:0] rem_sh [2];
  logic [SREM_W-1:0] trial  [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q[0] <= '0;
      center_q[1] <= '0;
      center_q[2] <= '0;
      normal_q[0] <= '0;
      normal_q[1] <= '0;
      normal_q[2] <= norm_t'(16384);
      busy_q      <= 1'b1;
      phase_q     <= PH_AXIS;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CENTER_X: center_q[0] <= cfg_data_i[COORD_W-1:0];
        CFG_CENTER_Y: center_q[1] <= cfg_data_i[COORD_W-1:0];
        CFG_CENTER_Z: center_q[2] <= cfg_data_i[COORD_W-1:0];
        CFG_NORMAL_X: normal_q[0] <= cfg_data_i[NORM_W-1:0];
        CFG_NORMAL_Y: normal_q[1] <= cfg_data_i[NORM_W-1:0];
        CFG_NORMAL_Z: normal_q[2] <= cfg_data_i[NORM_W-1:0];
        default: ;
      endcase
      busy_q  <= 1'b1;
      phase_q <= PH_AXIS;
    end else if (busy_q) begin
      if (phase_q == PH_ROOT_LAST) begin
        busy_q <= 1'b0;
      end
      phase_q <= phase_q + PH_W'(1);
    end
  end

  always_comb begin
    // First axis lies in the xy plane when the normal's z component is below NZ_THRESH (signed compare).
    if (normal_q[2] < norm_t'(NZ_THRESH)) begin
      xa_d[0] = -axis_t'(normal_q[1]);
      xa_d[1] = axis_t'(normal_q[0]);
      xa_d[2] = '0;
    end else begin
      xa_d[0] = '0;
      xa_d[1] = -axis_t'(normal_q[2]);
      xa_d[2] = axis_t'(normal_q[1]);
    end
    cross_c[0] = CROSS_W'(normal_q[1]) * CROSS_W'(xa_q[2])
               - CROSS_W'(normal_q[2]) * CROSS_W'(xa_q[1]);
    cross_c[1] = CROSS_W'(normal_q[2]) * CROSS_W'(xa_q[0])
               - CROSS_W'(normal_q[0]) * CROSS_W'(xa_q[2]);
    cross_c[2] = CROSS_W'(normal_q[0]) * CROSS_W'(xa_q[1])
               - CROSS_W'(normal_q[1]) * CROSS_W'(xa_q[0]);
    for (int i = 0; i < 3; i++) begin
      cross_r[i] = cross_c[i] + (CROSS_W'(1) << (NORM_FRAC - 1));
      ya_d[i]    = cross_r[i][NORM_FRAC +: AXIS_W];
    end
    len2_x = LEN2_W'(xa_q[0]) * LEN2_W'(xa_q[0]) + LEN2_W'(xa_q[1]) * LEN2_W'(xa_q[1])
           + LEN2_W'(xa_q[2]) * LEN2_W'(xa_q[2]);
    len2_y = LEN2_W'(ya_q[0]) * LEN2_W'(ya_q[0]) + LEN2_W'(ya_q[1]) * LEN2_W'(ya_q[1])
           + LEN2_W'(ya_q[2]) * LEN2_W'(ya_q[2]);
    // One root bit per cycle: two radicand bits enter the partial remainder.
    for (int l = 0; l < 2; l++) begin
      rem_sh[l] = {srem_q[l][SREM_W-3:0], rad_q[l][RAD_W-1:RAD_W-2]};
      trial[l]  = {1'b0, root_q[l], 2'b01};
      rad_d[l]  = rad_q[l] << 2;
      if (rem_sh[l] >= trial[l]) begin
        srem_d[l] = rem_sh[l] - trial[l];
        root_d[l] = {root_q[l][DEN_W-2:0], 1'b1};
      end else begin
        srem_d[l] = rem_sh[l];
        root_d[l] = {root_q[l][DEN_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !cfg_valid_i) begin
      case (phase_q)
        PH_AXIS:  xa_q <= xa_d;
        PH_CROSS: ya_q <= ya_d;
        PH_LOAD: begin
          rad_q[0]  <= RAD_W'(unsigned'(len2_x)) << (2 * LEN_SCALE);
          rad_q[1]  <= RAD_W'(unsigned'(len2_y)) << (2 * LEN_SCALE);
          srem_q[0] <= '0;
          srem_q[1] <= '0;
          root_q[0] <= '0;
          root_q[1] <= '0;
        end
        default: begin
          rad_q  <= rad_d;
          srem_q <= srem_d;
          root_q <= root_d;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cfg_o.center[i] = center_q[i];
      cfg_o.normal[i] = normal_q[i];
      cfg_o.xa[i]     = xa_q[i];
      cfg_o.ya[i]     = ya_q[i];
    end
    cfg_o.den_x = root_q[0];
    cfg_o.den_y = root_q[1];
  end

  assign busy_o = busy_q;

endmodule

>>> rtl/tpp_front.sv
// ----------------------------------------------------------------------------
// Tangent plane projector front pipeline
// Offsets, dot products, normal removal and divider operand setup.
// ----------------------------------------------------------------------------
module tpp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              accept_i,
  input  tpp_pkg::in_item_t item_i,
  input  tpp_pkg::cfg_t     cfg_i,
  output logic              valid_o,
  output tpp_pkg::side_t    side_o,
  output tpp_pkg::div_req_t req_x_o,
  output tpp_pkg::div_req_t req_y_o
);
  import tpp_pkg::*;

  localparam int RND_W = DOTP_W - NORM_FRAC;
  localparam int RES_W = RND_W + 1;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  function automatic coord_t sat_coord(input logic signed [RES_W-1:0] v);
    logic [RES_W-COORD_W:0] hi;
    hi = v[RES_W-1:COORD_W-1];
    if (hi == '0 || hi == '1) begin
      return v[COORD_W-1:0];
    end else if (v[RES_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  coord_t center [3];
  norm_t  normal [3];
  axis_t  xa [3];
  axis_t  ya [3];
  coord_t in_c [3];

  logic [4:0] v_q;
  logic [1:0] kind1_q, kind2_q, kind3_q, kind4_q;
  diff_t d1_q [3];
  diff_t d2_q [3];
  diff_t d3_q [3];
  diff_t d4_q [3];
  diff_t d1_d [3];
  prod_t pa_q [3];
  prod_t pb_q [3];
  prod_t pa_d [3];
  prod_t pb_d [3];
  axis_t fa [3];
  logic signed [SUM_W-1:0]  suma_q, sumb_q, suma_d, sumb_d, dot_rnd;
  logic signed [DOT_W-1:0]  dot_q, dot_d;
  logic signed [DOTP_W-1:0] qp_q [3];
  logic signed [DOTP_W-1:0] qp_d [3];
  logic signed [DOTP_W-1:0] qp_rnd [3];
  logic signed [RND_W-1:0]  rq [3];
  logic [SUM_W-1:0] absx, absy;
  logic [REM_W-1:0] magx_q, magy_q, magx_d, magy_d, tx, ty;
  logic             negx_q, negy_q;
  coord_t           r_d [3];
  side_t            side_q;
  div_req_t         reqx_q, reqy_q, reqx_d, reqy_d;

  always_comb begin
    in_c[0] = item_i.in_x;
    in_c[1] = item_i.in_y;
    in_c[2] = item_i.in_z;
    for (int i = 0; i < 3; i++) begin
      center[i] = cfg_i.center[i];
      normal[i] = cfg_i.normal[i];
      xa[i]     = cfg_i.xa[i];
      ya[i]     = cfg_i.ya[i];
      // Vectors are taken as they are; points and plane items are offset from the center.
      if (item_i.kind != KIND_VECTOR) begin
        d1_d[i] = diff_t'(in_c[i]) - diff_t'(center[i]);
      end else begin
        d1_d[i] = diff_t'(in_c[i]);
      end
      fa[i]   = (kind1_q == KIND_PLANE) ? xa[i] : axis_t'(normal[i]);
      pa_d[i] = prod_t'(d1_q[i]) * prod_t'(fa[i]);
      pb_d[i] = prod_t'(d1_q[i]) * prod_t'(ya[i]);
    end
    suma_d  = SUM_W'(pa_q[0]) + SUM_W'(pa_q[1]) + SUM_W'(pa_q[2]);
    sumb_d  = SUM_W'(pb_q[0]) + SUM_W'(pb_q[1]) + SUM_W'(pb_q[2]);
    dot_rnd = suma_d + (SUM_W'(1) << (NORM_FRAC - 1));
    dot_d   = dot_rnd[SUM_W-1:NORM_FRAC];
    for (int i = 0; i < 3; i++) begin
      qp_d[i]   = DOTP_W'(dot_q) * DOTP_W'(normal[i]);
      qp_rnd[i] = qp_q[i] + (DOTP_W'(1) << (NORM_FRAC - 1));
      rq[i]     = qp_rnd[i][DOTP_W-1:NORM_FRAC];
      r_d[i]    = sat_coord(RES_W'(d4_q[i]) - RES_W'(rq[i]));
    end
    absx   = suma_q[SUM_W-1] ? SUM_W'(-suma_q) : SUM_W'(suma_q);
    absy   = sumb_q[SUM_W-1] ? SUM_W'(-sumb_q) : SUM_W'(sumb_q);
    magx_d = REM_W'(absx) << LEN_SCALE;
    magy_d = REM_W'(absy) << LEN_SCALE;
    // Adding half the divisor makes the truncating divider round half up.
    tx = magx_q + REM_W'(cfg_i.den_x >> 1);
    ty = magy_q + REM_W'(cfg_i.den_y >> 1);
    reqx_d.t          = tx;
    reqx_d.flags.neg  = negx_q;
    reqx_d.flags.zero = (cfg_i.den_x == '0);
    reqx_d.flags.ovf  = (tx >= (REM_W'(cfg_i.den_x) << QUO_W));
    reqy_d.t          = ty;
    reqy_d.flags.neg  = negy_q;
    reqy_d.flags.zero = (cfg_i.den_y == '0);
    reqy_d.flags.ovf  = (ty >= (REM_W'(cfg_i.den_y) << QUO_W));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], accept_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind1_q <= item_i.kind;
      d1_q    <= d1_d;
      kind2_q <= kind1_q;
      d2_q    <= d1_q;
      pa_q    <= pa_d;
      pb_q    <= pb_d;
      kind3_q <= kind2_q;
      d3_q    <= d2_q;
      suma_q  <= suma_d;
      sumb_q  <= sumb_d;
      dot_q   <= dot_d;
      kind4_q <= kind3_q;
      d4_q    <= d3_q;
      qp_q    <= qp_d;
      magx_q  <= magx_d;
      magy_q  <= magy_d;
      negx_q  <= suma_q[SUM_W-1];
      negy_q  <= sumb_q[SUM_W-1];
      side_q.kind      <= kind4_q;
      side_q.res.out_x <= r_d[0];
      side_q.res.out_y <= r_d[1];
      side_q.res.out_z <= r_d[2];
      reqx_q <= reqx_d;
      reqy_q <= reqy_d;
    end
  end

  assign valid_o = v_q[4];
  assign side_o  = side_q;
  assign req_x_o = reqx_q;
  assign req_y_o = reqy_q;

endmodule

>>> rtl/tpp_div.sv
// ----------------------------------------------------------------------------
// Tangent plane projector divider lane
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module tpp_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  tpp_pkg::div_req_t          req_i,
  input  logic [tpp_pkg::DEN_W-1:0]  den_i,
  output tpp_pkg::coord_t            coord_o
);
  import tpp_pkg::*;

  logic [REM_W-1:0] rem_src [QUO_W];
  logic [QUO_W-1:0] quo_src [QUO_W];
  div_flags_t       flg_src [QUO_W];
  logic [REM_W-1:0] rem_q   [QUO_W];
  logic [QUO_W-1:0] quo_q   [QUO_W];
  div_flags_t       flg_q   [QUO_W];
  logic [REM_W-1:0] rem_d   [QUO_W];
  logic [QUO_W-1:0] quo_d   [QUO_W];
  logic [REM_W-1:0] trial   [QUO_W];
  logic [QUO_W-1:0] quo;
  div_flags_t       flg;

  always_comb begin
    rem_src[0] = req_i.t;
    quo_src[0] = '0;
    flg_src[0] = req_i.flags;
    for (int k = 1; k < QUO_W; k++) begin
      rem_src[k] = rem_q[k-1];
      quo_src[k] = quo_q[k-1];
      flg_src[k] = flg_q[k-1];
    end
    for (int k = 0; k < QUO_W; k++) begin
      trial[k] = REM_W'(den_i) << (QUO_W - 1 - k);
      if (rem_src[k] >= trial[k]) begin
        rem_d[k] = rem_src[k] - trial[k];
        quo_d[k] = {quo_src[k][QUO_W-2:0], 1'b1};
      end else begin
        rem_d[k] = rem_src[k];
        quo_d[k] = {quo_src[k][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      flg_q <= flg_src;
    end
  end

  assign quo = quo_q[QUO_W-1];
  assign flg = flg_q[QUO_W-1];

  always_comb begin
    if (flg.zero) begin
      coord_o = '0;
    end else if (flg.neg) begin
      coord_o = (flg.ovf || quo[QUO_W-1]) ? {1'b1, {(QUO_W-1){1'b0}}} : coord_t'(-quo);
    end else begin
      coord_o = (flg.ovf || quo[QUO_W-1]) ? {1'b0, {(QUO_W-1){1'b1}}} : coord_t'(quo);
    end
  end

endmodule

>>> rtl/tangent_plane_projector_top.sv
// Throughput: one item per cycle while neither a setup pass nor a full output
// buffer stalls the input; the front (5 stages) and the two divider lanes (one
// stage per quotient bit) are fully pipelined. Reset and every configuration
// write start a setup pass (axes, then a bit-serial square root per axis)
// during which input is stalled.
// ----------------------------------------------------------------------------
// Tangent plane projector top level
// Projects points and vectors onto the tangent plane set by a center and normal; plane items get axis coordinates.
// ----------------------------------------------------------------------------
module tangent_plane_projector_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  tpp_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output tpp_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tpp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tpp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tpp_pkg::*;

  logic      busy;
  cfg_t      cfg;
  logic      en;
  logic      accept;
  logic      front_valid;
  side_t     front_side;
  div_req_t  req_x, req_y;
  coord_t    coord_x, coord_y;

  logic [QUO_W-1:0] sv_q;
  side_t     side_q [QUO_W];
  side_t     side_src [QUO_W];
  out_item_t result;

  logic [1:0] count_q;
  out_item_t  head_q, skid_q;
  logic       push, pop;

  assign cfg_ready_o = 1'b1;
  assign en          = (count_q != 2'd2);
  assign in_stall_o  = busy || !en;
  assign accept      = in_valid_i && !in_stall_o;

  tpp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .cfg_o       (cfg)
  );

  tpp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .accept_i (accept),
    .item_i   (in_data_i),
    .cfg_i    (cfg),
    .valid_o  (front_valid),
    .side_o   (front_side),
    .req_x_o  (req_x),
    .req_y_o  (req_y)
  );

  tpp_div u_div_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .req_i   (req_x),
    .den_i   (cfg.den_x),
    .coord_o (coord_x)
  );

  tpp_div u_div_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .req_i   (req_y),
    .den_i   (cfg.den_y),
    .coord_o (coord_y)
  );

  // Kind and tangent results ride alongside the divider lanes.
  always_comb begin
    side_src[0] = front_side;
    for (int k = 1; k < QUO_W; k++) begin
      side_src[k] = side_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else if (en) begin
      sv_q <= {sv_q[QUO_W-2:0], front_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q <= side_src;
    end
  end

  always_comb begin
    case (side_q[QUO_W-1].kind) inside
      KIND_POINT, KIND_VECTOR: result = side_q[QUO_W-1].res;
      KIND_PLANE: begin
        result.out_x = coord_x;
        result.out_y = coord_y;
        result.out_z = '0;
      end
      default: result = '0;
    endcase
  end

  // Two-entry output buffer: the pipeline keeps moving while one item waits.
  assign push = en && sv_q[QUO_W-1];
  assign pop  = (count_q != 2'd0) && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (count_q == 2'd2) begin
      if (pop) begin
        head_q <= skid_q;
      end
    end else if (push) begin
      if (count_q == 2'd0 || pop) begin
        head_q <= result;
      end else begin
        skid_q <= result;
      end
    end
  end

  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = head_q;

endmodule
